// ===== design/asmc_pkg.sv =====
`timescale 1ns / 1ps

package asmc_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_SLOPE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINEAR_GAIN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADAPT_RATE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_GAIN = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_FLOOR = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_BAND = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_ANGULAR_MODE = 3'd7;

	localparam logic [CFG_DATA_W-1:0] SAMPLE_PERIOD_RST = 31'd655;
	localparam logic [CFG_DATA_W-1:0] SURFACE_SLOPE_RST = 31'd65536;
	localparam logic [CFG_DATA_W-1:0] LINEAR_GAIN_RST = 31'd65536;
	localparam logic [CFG_DATA_W-1:0] ADAPT_RATE_RST = 31'd65536;
	localparam logic [CFG_DATA_W-1:0] INITIAL_GAIN_RST = 31'd65536;
	localparam logic [CFG_DATA_W-1:0] GAIN_FLOOR_RST = 31'd6554;
	localparam logic [CFG_DATA_W-1:0] SURFACE_BAND_RST = 31'd6554;
	localparam logic ANGULAR_MODE_RST = 1'b0;

	// Pi and two pi with 30 fraction bits.
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_WRAP,
		ST_SURF_MUL,
		ST_SURF_ADD,
		ST_RATE,
		ST_GAIN_MUL,
		ST_GAIN_ADD,
		ST_ROOT_WAIT,
		ST_T1_MUL,
		ST_T1_TAKE,
		ST_T2_MUL,
		ST_DRV_NEG,
		ST_DRV_SUB,
		ST_OUT
	} asmc_state_t;

endpackage

// ===== design/asmc_mul.sv =====
`timescale 1ns / 1ps

module asmc_mul
	import asmc_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [DATA_WIDTH-1:0] a,
	input logic signed [DATA_WIDTH-1:0] b,
	output logic busy,
	output logic signed [DATA_WIDTH-1:0] product
);

	localparam int PW = 2 * DATA_WIDTH;
	localparam int CW = $clog2(DATA_WIDTH);
	localparam logic [PW-1:0] LIM_POS = {{(DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic [PW-1:0] LIM_NEG = LIM_POS + PW'(1);

	logic busy_q;
	logic fin_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [PW-1:0] ma_q;
	logic [DATA_WIDTH-1:0] mb_q;
	logic [PW-1:0] acc_q;
	logic signed [DATA_WIDTH-1:0] product_q;

	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [PW-1:0] q_full;
	logic [PW-1:0] lim;
	logic [DATA_WIDTH-1:0] q_low;

	assign a_mag = a[DATA_WIDTH-1] ? -a : a;
	assign b_mag = b[DATA_WIDTH-1] ? -b : b;
	assign q_full = acc_q >> FRAC_BITS;
	assign lim = neg_q ? LIM_NEG : LIM_POS;
	assign q_low = q_full[DATA_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q && fin_q) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DATA_WIDTH - 1)) begin
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			ma_q <= PW'(a_mag);
			mb_q <= b_mag;
			acc_q <= '0;
		end else if (busy_q && fin_q) begin
			if (q_full >= lim) begin
				product_q <= neg_q ? ~LIM_POS[DATA_WIDTH-1:0] : LIM_POS[DATA_WIDTH-1:0];
			end else begin
				product_q <= neg_q ? -q_low : q_low;
			end
		end else if (busy_q) begin
			if (mb_q[0]) begin
				acc_q <= acc_q + ma_q;
			end
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end

	assign busy = busy_q;
	assign product = product_q;

endmodule

// ===== design/asmc_sqrt.sv =====
`timescale 1ns / 1ps

module asmc_sqrt
	import asmc_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DATA_WIDTH-1:0] radicand,
	output logic busy,
	output logic signed [DATA_WIDTH-1:0] root
);

	localparam int RW = DATA_WIDTH + FRAC_BITS;
	localparam int RW2 = RW + (RW % 2);
	localparam int N = RW2 / 2;
	localparam int CW = $clog2(N);
	localparam int NW = (N > DATA_WIDTH) ? N : DATA_WIDTH;
	localparam logic [NW-1:0] VMAX_N = NW'({(DATA_WIDTH - 1){1'b1}});

	logic busy_q;
	logic fin_q;
	logic [CW-1:0] cnt_q;
	logic [RW2-1:0] rad_q;
	logic [N+1:0] rem_q;
	logic [N-1:0] res_q;
	logic signed [DATA_WIDTH-1:0] root_q;

	logic [N+1:0] rem_sh;
	logic [N+1:0] trial;
	logic [NW-1:0] res_ext;

	assign rem_sh = {rem_q[N-1:0], rad_q[RW2-1 -: 2]};
	assign trial = {res_q, 2'b01};
	assign res_ext = NW'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q && fin_q) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(N - 1)) begin
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= RW2'({radicand, {FRAC_BITS{1'b0}}});
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q && fin_q) begin
			root_q <= (res_ext > VMAX_N) ? VMAX_N[DATA_WIDTH-1:0] : res_ext[DATA_WIDTH-1:0];
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				res_q <= {res_q[N-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				res_q <= {res_q[N-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== design/adaptive_sliding_mode_controller_top.sv =====
`timescale 1ns / 1ps
// A control step passes the error, wrap, surface, rate, gain, root and drive states before its
// result; a clear item goes straight to output. No new item is taken until the result is loaded.
// The time is set by one shift-add multiplier that retires one multiplier bit per cycle and
// forms four products in turn; the square root runs beside it one result bit per cycle.
// Reset is asynchronous and active low: registers return to their defaults, the gain is
// loaded with the default initial gain and the previous gain rate is cleared.

module adaptive_sliding_mode_controller_top
	import asmc_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic signed [31:0] position,
	input logic signed [31:0] velocity,
	input logic signed [31:0] target_position,
	input logic signed [31:0] target_velocity,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] drive,
	output logic signed [31:0] gain_now,
	output logic signed [31:0] surface
);

	localparam int DW = DATA_WIDTH;
	localparam int WW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 2;
	localparam logic signed [WW-1:0] VMAX_W = {{(WW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
	localparam logic signed [WW-1:0] VMIN_W = ~VMAX_W;
	localparam logic signed [WW-1:0] OMAX_W = {{(WW - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [WW-1:0] OMIN_W = ~OMAX_W;

	localparam int SH = 30 - FRAC_BITS;
	localparam logic [63:0] PI_RND = (PI_Q30 + ((64'd1 << SH) >> 1)) >> SH;
	localparam logic [63:0] TWO_PI_RND = (TWO_PI_Q30 + ((64'd1 << SH) >> 1)) >> SH;
	localparam logic [63:0] VMAX64 = (64'd1 << (DW - 1)) - 64'd1;
	localparam logic [127:0] PI_EXT = {64'd0, ((PI_RND > VMAX64) ? VMAX64 : PI_RND)};
	localparam logic [127:0] TWO_PI_EXT = {64'd0, ((TWO_PI_RND > VMAX64) ? VMAX64 : TWO_PI_RND)};
	localparam logic signed [WW-1:0] PI_W = PI_EXT[WW-1:0];
	localparam logic signed [WW-1:0] NEG_PI_W = -PI_W;
	localparam logic signed [WW-1:0] TWO_PI_W = TWO_PI_EXT[WW-1:0];

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [WW-1:0] x);
		if (x > VMAX_W) begin
			return VMAX_W[DW-1:0];
		end else if (x < VMIN_W) begin
			return VMIN_W[DW-1:0];
		end
		return x[DW-1:0];
	endfunction

	function automatic logic signed [31:0] sat_out(input logic signed [WW-1:0] x);
		if (x > OMAX_W) begin
			return OMAX_W[31:0];
		end else if (x < OMIN_W) begin
			return OMIN_W[31:0];
		end
		return x[31:0];
	endfunction

	function automatic logic signed [WW-1:0] ext(input logic signed [DW-1:0] x);
		return WW'(x);
	endfunction

	function automatic logic signed [DW-1:0] wrap_err(input logic signed [DW-1:0] e);
		logic signed [WW-1:0] ew;
		ew = ext(e);
		if (ew > PI_W) begin
			return sat_dw(ew - TWO_PI_W);
		end else if (ew < NEG_PI_W) begin
			return sat_dw(ew + TWO_PI_W);
		end
		return e;
	endfunction

	localparam logic signed [DW-1:0] GAIN_RST = sat_dw(WW'(INITIAL_GAIN_RST));

	asmc_state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] period_q;
	logic [CFG_DATA_W-1:0] slope_q;
	logic [CFG_DATA_W-1:0] lin_gain_q;
	logic [CFG_DATA_W-1:0] adapt_q;
	logic [CFG_DATA_W-1:0] floor_q;
	logic [CFG_DATA_W-1:0] band_q;
	logic angular_q;

	logic signed [31:0] pos_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] tpos_q;
	logic signed [31:0] tvel_q;
	logic signed [DW-1:0] e1_q;
	logic signed [DW-1:0] e2_q;
	logic signed [DW-1:0] s_q;
	logic signed [DW-1:0] half_q;
	logic signed [DW-1:0] last_rate_q;
	logic signed [DW-1:0] gain_q;
	logic signed [DW-1:0] t1_q;
	logic signed [DW-1:0] drive_q;
	logic out_valid_q;
	logic signed [31:0] drive_out_q;
	logic signed [31:0] gain_out_q;
	logic signed [31:0] surface_out_q;

	logic signed [DW-1:0] period_d;
	logic signed [DW-1:0] slope_d;
	logic signed [DW-1:0] lin_gain_d;
	logic signed [DW-1:0] adapt_d;
	logic signed [DW-1:0] floor_d;
	logic signed [DW-1:0] band_d;

	logic signed [DW-1:0] e1_d;
	logic signed [DW-1:0] e2_d;
	logic [DW-1:0] s_mag;
	logic signed [DW-1:0] rate_d;
	logic signed [DW:0] rate_sum;
	logic signed [DW:0] rate_adj;
	logic signed [DW-1:0] root_s;

	logic mul_start;
	logic signed [DW-1:0] mul_a;
	logic signed [DW-1:0] mul_b;
	logic mul_busy;
	logic signed [DW-1:0] mul_res;
	logic sqrt_start;
	logic sqrt_busy;
	logic signed [DW-1:0] sqrt_res;
	logic accept;
	logic out_load;

	assign period_d = sat_dw(WW'(period_q));
	assign slope_d = sat_dw(WW'(slope_q));
	assign lin_gain_d = sat_dw(WW'(lin_gain_q));
	assign adapt_d = sat_dw(WW'(adapt_q));
	assign floor_d = sat_dw(WW'(floor_q));
	assign band_d = sat_dw(WW'(band_q));

	assign e1_d = sat_dw(ext(sat_dw(WW'(tpos_q))) - ext(sat_dw(WW'(pos_q))));
	assign e2_d = sat_dw(ext(sat_dw(WW'(tvel_q))) - ext(sat_dw(WW'(vel_q))));
	assign s_mag = s_q[DW-1] ? -s_q : s_q;
	assign root_s = s_q[DW-1] ? -sqrt_res : sqrt_res;

	always_comb begin
		if (gain_q > floor_d) begin
			if (s_mag > band_d) begin
				rate_d = adapt_d;
			end else if (s_mag < band_d) begin
				rate_d = -adapt_d;
			end else begin
				rate_d = '0;
			end
		end else begin
			rate_d = floor_d;
		end
	end

	// Halving rounds toward zero, so a negative sum is bumped by one first.
	assign rate_sum = (DW + 1)'(rate_d) + (DW + 1)'(last_rate_q);
	assign rate_adj = rate_sum + $signed({{DW{1'b0}}, rate_sum[DW]});

	asmc_mul #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.busy(mul_busy),
		.product(mul_res)
	);

	asmc_sqrt #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.radicand(s_mag),
		.busy(sqrt_busy),
		.root(sqrt_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		sqrt_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = cmd ? ST_OUT : ST_ERR;
				end
			end
			ST_ERR: begin
				state_d = ST_WRAP;
			end
			ST_WRAP: begin
				state_d = ST_SURF_MUL;
			end
			ST_SURF_MUL: begin
				mul_start = 1'b1;
				mul_a = slope_d;
				mul_b = e1_q;
				state_d = ST_SURF_ADD;
			end
			ST_SURF_ADD: begin
				if (!mul_busy) begin
					state_d = ST_RATE;
				end
			end
			ST_RATE: begin
				sqrt_start = 1'b1;
				state_d = ST_GAIN_MUL;
			end
			ST_GAIN_MUL: begin
				mul_start = 1'b1;
				mul_a = half_q;
				mul_b = period_d;
				state_d = ST_GAIN_ADD;
			end
			ST_GAIN_ADD: begin
				if (!mul_busy) begin
					state_d = ST_ROOT_WAIT;
				end
			end
			ST_ROOT_WAIT: begin
				if (!sqrt_busy) begin
					state_d = ST_T1_MUL;
				end
			end
			ST_T1_MUL: begin
				mul_start = 1'b1;
				mul_a = gain_q;
				mul_b = root_s;
				state_d = ST_T1_TAKE;
			end
			ST_T1_TAKE: begin
				if (!mul_busy) begin
					state_d = ST_T2_MUL;
				end
			end
			ST_T2_MUL: begin
				mul_start = 1'b1;
				mul_a = lin_gain_d;
				mul_b = s_q;
				state_d = ST_DRV_NEG;
			end
			ST_DRV_NEG: begin
				if (!mul_busy) begin
					state_d = ST_DRV_SUB;
				end
			end
			ST_DRV_SUB: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= SAMPLE_PERIOD_RST;
			slope_q <= SURFACE_SLOPE_RST;
			lin_gain_q <= LINEAR_GAIN_RST;
			adapt_q <= ADAPT_RATE_RST;
			floor_q <= GAIN_FLOOR_RST;
			band_q <= SURFACE_BAND_RST;
			angular_q <= ANGULAR_MODE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SAMPLE_PERIOD: period_q <= cfg_data;
				CFG_SURFACE_SLOPE: slope_q <= cfg_data;
				CFG_LINEAR_GAIN: lin_gain_q <= cfg_data;
				CFG_ADAPT_RATE: adapt_q <= cfg_data;
				CFG_INITIAL_GAIN: begin
					// The initial gain only matters at reset, which loads its default.
				end
				CFG_GAIN_FLOOR: floor_q <= cfg_data;
				CFG_SURFACE_BAND: band_q <= cfg_data;
				CFG_ANGULAR_MODE: angular_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			last_rate_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && cmd) begin
				gain_q <= '0;
			end else if (state_q == ST_GAIN_ADD && !mul_busy) begin
				gain_q <= sat_dw(ext(gain_q) + ext(mul_res));
			end
			if (state_q == ST_RATE) begin
				last_rate_q <= rate_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
			vel_q <= velocity;
			tpos_q <= target_position;
			tvel_q <= target_velocity;
			if (cmd) begin
				s_q <= '0;
				drive_q <= '0;
			end
		end
		case (state_q)
			ST_ERR: begin
				e1_q <= e1_d;
				e2_q <= e2_d;
			end
			ST_WRAP: begin
				if (angular_q) begin
					e1_q <= wrap_err(e1_q);
					e2_q <= wrap_err(e2_q);
				end
			end
			ST_SURF_ADD: begin
				if (!mul_busy) begin
					s_q <= sat_dw(ext(e2_q) + ext(mul_res));
				end
			end
			ST_RATE: begin
				half_q <= rate_adj[DW:1];
			end
			ST_T1_TAKE: begin
				if (!mul_busy) begin
					t1_q <= mul_res;
				end
			end
			ST_DRV_NEG: begin
				if (!mul_busy) begin
					drive_q <= sat_dw(-ext(t1_q));
				end
			end
			ST_DRV_SUB: begin
				drive_q <= sat_dw(ext(drive_q) - ext(mul_res));
			end
			default: begin
			end
		endcase
		if (out_load) begin
			drive_out_q <= sat_out(ext(drive_q));
			gain_out_q <= sat_out(ext(gain_q));
			surface_out_q <= sat_out(ext(s_q));
		end
	end

	assign out_valid = out_valid_q;
	assign drive = drive_out_q;
	assign gain_now = gain_out_q;
	assign surface = surface_out_q;

endmodule

// ===== tb/tb_adaptive_sliding_mode_controller_top.sv =====
`timescale 1ns / 1ps

module tb_adaptive_sliding_mode_controller_top;
	import asmc_pkg::*;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint PI_Q = 205887;
	localparam longint TWO_PI_Q = 411775;
	localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] PI_V = 32'sd205887;
	localparam logic [CFG_DATA_W-1:0] REG_MAX = 31'h7FFF_FFFF;
	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam int RANDOM_ITEMS = 1700;
	localparam int PHASES = 8;
	localparam int HOLD_CYCLES = 1500;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 200;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic cmd;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] tpos;
		logic signed [31:0] tvel;
	} step_t;

	typedef struct {
		logic signed [31:0] drive;
		logic signed [31:0] gain;
		logic signed [31:0] surf;
	} ctrl_out_t;

	typedef struct {
		bit is_reg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] val;
		step_t stim;
		bit typed;
		ctrl_out_t want;
	} dir_row_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] period;
		logic [CFG_DATA_W-1:0] slope;
		logic [CFG_DATA_W-1:0] lin_gain;
		logic [CFG_DATA_W-1:0] rate_k;
		logic [CFG_DATA_W-1:0] init_k;
		logic [CFG_DATA_W-1:0] floor_k;
		logic [CFG_DATA_W-1:0] band;
		logic wrap;
	} tuning_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic signed [31:0] position = '0;
	logic signed [31:0] velocity = '0;
	logic signed [31:0] target_position = '0;
	logic signed [31:0] target_velocity = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] drive;
	logic signed [31:0] gain_now;
	logic signed [31:0] surface;

	longint period_q, slope_q, lin_q, rate_k_q, floor_q, band_q;
	logic wrap_on;
	longint gain_k1, prev_rate;

	ctrl_out_t pending_outputs[$];
	dir_row_t rows[$];
	ctrl_out_t rx_want;
	int send_idle = 16;
	int recv_idle = 69;
	int failures = 0;
	int results_checked = 0;
	int n_steps = 0;
	int n_clears = 0;
	int n_settings = 1;
	int cycle_count = 0;
	int hold_left = 0;
	logic hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #6 clk = ~clk;

	adaptive_sliding_mode_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.position(position),
		.velocity(velocity),
		.target_position(target_position),
		.target_velocity(target_velocity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.gain_now(gain_now),
		.surface(surface)
	);

	function automatic longint sat(input longint x);
		if (x > Q_MAX) return Q_MAX;
		if (x < Q_MIN) return Q_MIN;
		return x;
	endfunction

	function automatic longint add_sat(input longint a, input longint b);
		return sat(a + b);
	endfunction

	function automatic longint sub_sat(input longint a, input longint b);
		return sat(a - b);
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		logic [63:0] ma, mb, prod;
		longint q;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		prod = ma * mb;
		q = $signed(prod >> FRAC_BITS_DEF);
		if ((a < 0) != (b < 0))
			q = -q;
		return sat(q);
	endfunction

	function automatic longint qsqrt(input longint m);
		logic [63:0] x, r, cand;
		int b;
		x = m;
		x = x << FRAC_BITS_DEF;
		r = '0;
		for (b = 31; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= x)
				r = cand;
		end
		return $signed(r);
	endfunction

	function automatic longint wrap_angle(input longint e);
		if (e > PI_Q)
			return sub_sat(e, TWO_PI_Q);
		if (e < -PI_Q)
			return add_sat(e, TWO_PI_Q);
		return e;
	endfunction

	function automatic ctrl_out_t compute_control(input step_t st);
		longint e_pos, e_vel, s, ms, rate, half, root, t1, t2, drv;
		ctrl_out_t res;
		if (st.cmd == CMD_CLEAR) begin
			gain_k1 = 0;
			res.drive = '0;
			res.gain = '0;
			res.surf = '0;
			return res;
		end
		e_pos = sub_sat(longint'(st.tpos), longint'(st.pos));
		e_vel = sub_sat(longint'(st.tvel), longint'(st.vel));
		if (wrap_on) begin
			e_pos = wrap_angle(e_pos);
			e_vel = wrap_angle(e_vel);
		end
		s = add_sat(e_vel, qmul(slope_q, e_pos));
		ms = (s < 0) ? -s : s;
		if (gain_k1 > floor_q)
			rate = (ms > band_q) ? rate_k_q : ((ms < band_q) ? -rate_k_q : 0);
		else
			rate = floor_q;
		half = (rate + prev_rate) / 2;
		prev_rate = rate;
		gain_k1 = add_sat(gain_k1, qmul(half, period_q));
		root = qsqrt(ms);
		if (s < 0)
			root = -root;
		else if (s == 0)
			root = 0;
		t1 = qmul(gain_k1, root);
		t2 = qmul(lin_q, s);
		drv = sub_sat(sub_sat(0, t1), t2);
		res.drive = drv[31:0];
		res.gain = gain_k1[31:0];
		res.surf = s[31:0];
		return res;
	endfunction

	task automatic reset_model();
		period_q = 655;
		slope_q = 65536;
		lin_q = 65536;
		rate_k_q = 65536;
		floor_q = 6554;
		band_q = 6554;
		wrap_on = 1'b0;
		gain_k1 = 65536;
		prev_rate = 0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SAMPLE_PERIOD: period_q = longint'(val);
			CFG_SURFACE_SLOPE: slope_q = longint'(val);
			CFG_LINEAR_GAIN: lin_q = longint'(val);
			CFG_ADAPT_RATE: rate_k_q = longint'(val);
			CFG_INITIAL_GAIN: ;
			CFG_GAIN_FLOOR: floor_q = longint'(val);
			CFG_SURFACE_BAND: band_q = longint'(val);
			CFG_ANGULAR_MODE: wrap_on = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_tuning(input tuning_t t);
		settle();
		write_reg(CFG_SAMPLE_PERIOD, t.period);
		write_reg(CFG_SURFACE_SLOPE, t.slope);
		write_reg(CFG_LINEAR_GAIN, t.lin_gain);
		write_reg(CFG_ADAPT_RATE, t.rate_k);
		write_reg(CFG_INITIAL_GAIN, t.init_k);
		write_reg(CFG_GAIN_FLOOR, t.floor_k);
		write_reg(CFG_SURFACE_BAND, t.band);
		write_reg(CFG_ANGULAR_MODE, {30'd0, t.wrap});
	endtask

	task automatic offer_item(input step_t st);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= st.cmd;
		position <= st.pos;
		velocity <= st.vel;
		target_position <= st.tpos;
		target_velocity <= st.tvel;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_and_predict(input step_t st, input bit typed, input ctrl_out_t want);
		ctrl_out_t got;
		offer_item(st);
		got = compute_control(st);
		if (st.cmd == CMD_CLEAR)
			n_clears++;
		else
			n_steps++;
		if (typed)
			pending_outputs.push_back(want);
		else
			pending_outputs.push_back(got);
	endtask

	task automatic add_step(input logic signed [31:0] p, v, tp, tv);
		dir_row_t r;
		r.is_reg = 1'b0;
		r.idx = '0;
		r.val = '0;
		r.stim.cmd = CMD_STEP;
		r.stim.pos = p;
		r.stim.vel = v;
		r.stim.tpos = tp;
		r.stim.tvel = tv;
		r.typed = 1'b0;
		r.want = '{default: '0};
		rows.push_back(r);
	endtask

	task automatic add_clear(input logic signed [31:0] p, v);
		dir_row_t r;
		r.is_reg = 1'b0;
		r.idx = '0;
		r.val = '0;
		r.stim.cmd = CMD_CLEAR;
		r.stim.pos = p;
		r.stim.vel = v;
		r.stim.tpos = ~p;
		r.stim.tvel = ~v;
		r.typed = 1'b1;
		r.want = '{default: '0};
		rows.push_back(r);
	endtask

	task automatic add_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r.is_reg = 1'b1;
		r.idx = idx;
		r.val = val;
		r.stim = '{default: '0};
		r.typed = 1'b0;
		r.want = '{default: '0};
		rows.push_back(r);
	endtask

	task automatic build_table();
		add_step(0, 0, 0, 0);
		add_step(0, 0, 0, 6554);
		add_step(0, 0, 0, -6554);
		add_step(0, 0, 0, 6555);
		add_step(V_MIN, V_MIN, V_MAX, V_MAX);
		add_step(V_MAX, V_MAX, V_MIN, V_MIN);
		add_step(V_MAX, V_MAX, V_MAX, V_MAX);
		add_step(V_MIN, V_MIN, V_MIN, V_MIN);
		add_clear(V_MAX, V_MIN);
		add_step(0, 0, 0, 0);
		add_step(0, 0, 6554, 0);
		add_clear(V_MIN, V_MAX);
		add_reg(CFG_ANGULAR_MODE, 31'd1);
		add_step(0, 0, PI_V + 1, 0);
		add_step(0, 0, -PI_V - 1, 0);
		add_step(0, 0, PI_V, -PI_V - 1);
		add_step(0, 0, -PI_V, PI_V + 1);
		add_step(V_MIN, V_MAX, V_MAX, V_MIN);
		add_step(V_MAX, V_MIN, V_MIN, V_MAX);
		add_clear(0, 0);
		add_step(1000, -2000, 1000 + PI_V, -2000 - PI_V);
		add_reg(CFG_ANGULAR_MODE, 31'd0);
		add_step(0, 0, PI_V + 1, -PI_V - 1);
	endtask

	function automatic logic signed [31:0] pick_value();
		int tmp;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3: return V_MAX;
			4: return V_MIN;
			5: return '0;
			6: return int'($urandom_range(0, 1048576)) - 524288;
			7: begin
				tmp = int'(PI_Q) + int'($urandom_range(0, 4)) - 2;
				return $urandom_range(0, 1) ? tmp : -tmp;
			end
			8: return int'($urandom_range(0, 16)) - 8;
			default: return int'($urandom_range(0, 1)) ? 6554 + int'($urandom_range(0, 2)) - 1
				: -6554 + int'($urandom_range(0, 2)) - 1;
		endcase
	endfunction

	function automatic step_t random_step();
		step_t st;
		st.cmd = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_STEP;
		st.pos = pick_value();
		st.vel = pick_value();
		st.tpos = $urandom_range(0, 1) ? st.pos + pick_value() : pick_value();
		st.tvel = $urandom_range(0, 1) ? st.vel + pick_value() : pick_value();
		return st;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return REG_MAX;
			2: return CFG_DATA_W'($urandom_range(0, 131072));
			3: return CFG_DATA_W'($urandom_range(0, 2000));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic tuning_t make_tuning(input int p);
		tuning_t t;
		case (p)
			0: t = '{REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, 1'b1};
			1: t = '{'0, '0, '0, '0, '0, '0, '0, 1'b0};
			2: t = '{31'd655, 31'd65536, 31'd65536, 31'd65536, 31'd65536, 31'd6554, 31'd6554, 1'b0};
			default: begin
				t.period = pick_reg();
				t.slope = pick_reg();
				t.lin_gain = pick_reg();
				t.rate_k = pick_reg();
				t.init_k = pick_reg();
				t.floor_k = pick_reg();
				t.band = pick_reg();
				t.wrap = 1'($urandom_range(0, 1));
			end
		endcase
		return t;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_outputs.size() == 0) begin
					$error("result with no item waiting: drive %0d gain_now %0d surface %0d",
						drive, gain_now, surface);
					failures++;
				end else begin
					rx_want = pending_outputs.pop_front();
					results_checked++;
					if (drive !== rx_want.drive) begin
						$error("drive expected %0d actual %0d", rx_want.drive, drive);
						failures++;
					end
					if (gain_now !== rx_want.gain) begin
						$error("gain_now expected %0d actual %0d", rx_want.gain, gain_now);
						failures++;
					end
					if (surface !== rx_want.surf) begin
						$error("surface expected %0d actual %0d", rx_want.surf, surface);
						failures++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL adaptive_sliding_mode_controller_top");
		$finish;
	end

	initial begin : stimulus
		int p, j, k, per_phase;
		ctrl_out_t none;
		none = '{default: '0};
		per_phase = RANDOM_ITEMS / PHASES;
		reset_model();
		build_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_reg) begin
				settle();
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_and_predict(rows[i].stim, rows[i].typed, rows[i].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			apply_tuning(make_tuning(p));
			n_settings++;
			for (j = 0; j < per_phase; j++) begin
				k = p * per_phase + j;
				if (k < RANDOM_ITEMS / 3) begin
					send_idle = 16;
					recv_idle = 69;
				end else if (k < 2 * RANDOM_ITEMS / 3) begin
					send_idle = 69;
					recv_idle = 16;
				end else begin
					send_idle = 0;
					recv_idle = 0;
				end
				if (p == 4 && j == 100)
					hold_req = 1'b1;
				send_and_predict(random_step(), 1'b0, none);
			end
		end

		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d control steps and %0d gain clears over %0d settings.",
			results_checked, n_steps, n_clears, n_settings);
		$display("Covered saturation, angle wrap, band edges, mixed idling and a %0d-cycle output stall.",
			HOLD_CYCLES);
		if (failures == 0 && pending_outputs.size() == 0) begin
			$display("PASS adaptive_sliding_mode_controller_top");
		end else begin
			$display("FAIL adaptive_sliding_mode_controller_top");
		end
		$finish;
	end

endmodule
